// ===== rtl/core/tst_pkg.sv =====
// tst_pkg: sizes, command and status codes, and word types for the topic
// subscription table. No dependencies; used by topic_subscription_table.
package tst_pkg;

	localparam int NUM_CLIENTS       = 32;
	localparam int TOPICS_PER_CLIENT = 10;
	localparam int TOPIC_KEY_BITS    = 16;

	localparam int CID_W       = $clog2(NUM_CLIENTS);
	localparam int CNT_W       = $clog2(TOPICS_PER_CLIENT + 1);
	localparam int ENTRY_DEPTH = NUM_CLIENTS * TOPICS_PER_CLIENT;
	localparam int ADDR_W      = $clog2(ENTRY_DEPTH);
	localparam int KEY_W       = TOPIC_KEY_BITS;

	localparam logic [2:0] FN_CONNECT     = 3'd0;
	localparam logic [2:0] FN_DISCONNECT  = 3'd1;
	localparam logic [2:0] FN_SUBSCRIBE   = 3'd2;
	localparam logic [2:0] FN_UNSUBSCRIBE = 3'd3;
	localparam logic [2:0] FN_PUBLISH     = 3'd4;

	localparam logic [2:0] S_SUB_OK      = 3'd0;
	localparam logic [2:0] S_ALREADY     = 3'd1;
	localparam logic [2:0] S_LIMIT       = 3'd2;
	localparam logic [2:0] S_UNSUB_OK    = 3'd3;
	localparam logic [2:0] S_NOT_SUBBED  = 3'd4;
	localparam logic [2:0] S_DELIVER     = 3'd5;

	typedef struct packed {
		logic [2:0]  func;
		logic [4:0]  client_id;
		logic [15:0] topic_key;
	} tst_cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] dest_client;
		logic       last;
	} tst_res_t;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_DECODE   = 8'b0000_0010,
		ST_SCAN     = 8'b0000_0100,
		ST_RESOLVE  = 8'b0000_1000,
		ST_SHIFT_RD = 8'b0001_0000,
		ST_SHIFT_WR = 8'b0010_0000,
		ST_REPLY    = 8'b0100_0000,
		ST_FLUSH    = 8'b1000_0000
	} tst_state_t;

endpackage

// ===== rtl/core/topic_subscription_table.sv =====
// topic_subscription_table: per-client topic lists with publish fanout; uses tst_pkg.
// Connect/disconnect give no result word; subscribe scans the entries held by the client,
// and unsubscribe does the same and then moves each later entry down by one place.
// Publish scans the entries of every connected client and can wait on output stalls;
// cmd_stall is high until the command has finished.
// Reset (arst_n low, asynchronous) clears flags, counts and control; entries keep no reset.
module topic_subscription_table
	import tst_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  tst_cmd_t cmd,
	output logic     res_valid,
	input  logic     res_stall,
	output tst_res_t res
);

	tst_state_t state_q, state_d;

	logic [NUM_CLIENTS-1:0] conn_q;
	logic [CNT_W-1:0]       cnt_q [NUM_CLIENTS];

	logic [KEY_W-1:0] mem [ENTRY_DEPTH];
	logic [KEY_W-1:0] mem_rd_q;
	logic             mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [KEY_W-1:0] mem_wdata;

	logic [2:0]       func_q, func_d;
	logic [CID_W-1:0] cl_q, cl_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic [CNT_W-1:0] t_q, t_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic             found_q, found_d;
	logic             iss_done_q, iss_done_d;
	logic [2:0]       status_q, status_d;

	logic             valid_s1, valid_s1_d;
	logic [CID_W-1:0] tag_s1, tag_s1_d;
	logic [CNT_W-1:0] t_s1, t_s1_d;

	logic             pend_valid_q, pend_valid_d;
	logic [CID_W-1:0] pend_cl_q, pend_cl_d;

	logic     out_valid_q, out_load;
	tst_res_t out_q, out_d;

	logic             conn_we, conn_wd, cnt_we;
	logic [CNT_W-1:0] cnt_wd;

	logic             cur_conn, cid_ok, out_free, match_s1, advance, next_client;
	logic [CNT_W-1:0] cur_cnt;
	logic [ADDR_W-1:0] row_base;
	logic [63:0]      key_ext;

	assign cur_conn = conn_q[cl_q];
	assign cur_cnt  = cnt_q[cl_q];
	assign row_base = ADDR_W'(cl_q) * ADDR_W'(TOPICS_PER_CLIENT);
	assign key_ext  = 64'(cmd.topic_key);
	assign cid_ok   = 32'(cmd.client_id) < NUM_CLIENTS;
	assign out_free = !out_valid_q || !res_stall;
	assign match_s1 = valid_s1 && (mem_rd_q == key_q);
	// a second match needs the held delivery moved out first
	assign advance  = !(match_s1 && pend_valid_q && !out_free);

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		state_d      = state_q;
		func_d       = func_q;
		cl_d         = cl_q;
		key_d        = key_q;
		t_d          = t_q;
		pos_d        = pos_q;
		found_d      = found_q;
		iss_done_d   = iss_done_q;
		status_d     = status_q;
		valid_s1_d   = valid_s1;
		tag_s1_d     = tag_s1;
		t_s1_d       = t_s1;
		pend_valid_d = pend_valid_q;
		pend_cl_d    = pend_cl_q;
		out_load     = 1'b0;
		out_d        = out_q;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		mem_waddr    = row_base;
		mem_raddr    = row_base;
		mem_wdata    = key_q;
		conn_we      = 1'b0;
		conn_wd      = 1'b0;
		cnt_we       = 1'b0;
		cnt_wd       = '0;
		next_client  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					func_d = cmd.func;
					cl_d   = CID_W'(cmd.client_id);
					key_d  = key_ext[KEY_W-1:0];
					if (cid_ok && cmd.func <= FN_PUBLISH) begin
						state_d = ST_DECODE;
					end
				end
			end
			ST_DECODE: begin
				case (func_q) inside
					FN_CONNECT, FN_DISCONNECT: begin
						conn_we = 1'b1;
						conn_wd = (func_q == FN_CONNECT);
						cnt_we  = 1'b1;
						cnt_wd  = '0;
						state_d = ST_IDLE;
					end
					default: begin
						if (!cur_conn) begin
							state_d = ST_IDLE;
						end else begin
							t_d          = '0;
							found_d      = 1'b0;
							iss_done_d   = 1'b0;
							pend_valid_d = 1'b0;
							valid_s1_d   = 1'b0;
							if (func_q == FN_PUBLISH) begin
								cl_d = '0;
							end
							state_d = ST_SCAN;
						end
					end
				endcase
			end
			ST_SCAN: begin
				if (iss_done_q && !valid_s1) begin
					state_d = (func_q == FN_PUBLISH) ? ST_FLUSH : ST_RESOLVE;
				end else if (advance) begin
					valid_s1_d = 1'b0;
					// read side: one entry per cycle while no held delivery blocks advance
					if (!iss_done_q) begin
						if (cur_conn && t_q < cur_cnt) begin
							mem_re     = 1'b1;
							mem_raddr  = row_base + ADDR_W'(t_q);
							valid_s1_d = 1'b1;
							tag_s1_d   = cl_q;
							t_s1_d     = t_q;
							if ((t_q + CNT_W'(1)) == cur_cnt) begin
								next_client = 1'b1;
							end else begin
								t_d = t_q + CNT_W'(1);
							end
						end else begin
							next_client = 1'b1;
						end
						if (next_client) begin
							t_d = '0;
							if (func_q != FN_PUBLISH || cl_q == CID_W'(NUM_CLIENTS - 1)) begin
								iss_done_d = 1'b1;
							end else begin
								cl_d = cl_q + CID_W'(1);
							end
						end
					end
					// compare side
					if (match_s1) begin
						found_d = 1'b1;
						pos_d   = t_s1;
						if (func_q == FN_PUBLISH) begin
							if (pend_valid_q) begin
								out_load          = 1'b1;
								out_d.status      = S_DELIVER;
								out_d.dest_client = 5'(pend_cl_q);
								out_d.last        = 1'b0;
							end
							pend_valid_d = 1'b1;
							pend_cl_d    = tag_s1;
						end
					end
				end
			end
			ST_RESOLVE: begin
				state_d = ST_REPLY;
				if (func_q == FN_SUBSCRIBE) begin
					if (found_q) begin
						status_d = S_ALREADY;
					end else if (cur_cnt >= CNT_W'(TOPICS_PER_CLIENT)) begin
						status_d = S_LIMIT;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = row_base + ADDR_W'(cur_cnt);
						mem_wdata = key_q;
						cnt_we    = 1'b1;
						cnt_wd    = cur_cnt + CNT_W'(1);
						status_d  = S_SUB_OK;
					end
				end else begin
					if (!found_q) begin
						status_d = S_NOT_SUBBED;
					end else if ((pos_q + CNT_W'(1)) < cur_cnt) begin
						t_d     = pos_q;
						state_d = ST_SHIFT_RD;
					end else begin
						cnt_we   = 1'b1;
						cnt_wd   = cur_cnt - CNT_W'(1);
						status_d = S_UNSUB_OK;
					end
				end
			end
			ST_SHIFT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = row_base + ADDR_W'(t_q) + ADDR_W'(1);
				state_d   = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = row_base + ADDR_W'(t_q);
				mem_wdata = mem_rd_q;
				t_d       = t_q + CNT_W'(1);
				if ((t_q + CNT_W'(2)) < cur_cnt) begin
					state_d = ST_SHIFT_RD;
				end else begin
					cnt_we   = 1'b1;
					cnt_wd   = cur_cnt - CNT_W'(1);
					status_d = S_UNSUB_OK;
					state_d  = ST_REPLY;
				end
			end
			ST_REPLY: begin
				if (out_free) begin
					out_load          = 1'b1;
					out_d.status      = status_q;
					out_d.dest_client = 5'(cl_q);
					out_d.last        = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					out_load          = 1'b1;
					out_d.status      = S_DELIVER;
					out_d.dest_client = 5'(pend_cl_q);
					out_d.last        = 1'b1;
					pend_valid_d      = 1'b0;
					state_d           = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			conn_q       <= '0;
			cnt_q        <= '{default: '0};
			valid_s1     <= 1'b0;
			pend_valid_q <= 1'b0;
			iss_done_q   <= 1'b0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			valid_s1     <= valid_s1_d;
			pend_valid_q <= pend_valid_d;
			iss_done_q   <= iss_done_d;
			found_q      <= found_d;
			if (conn_we) begin
				conn_q[cl_q] <= conn_wd;
			end
			if (cnt_we) begin
				cnt_q[cl_q] <= cnt_wd;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		func_q    <= func_d;
		cl_q      <= cl_d;
		key_q     <= key_d;
		t_q       <= t_d;
		pos_q     <= pos_d;
		status_q  <= status_d;
		tag_s1    <= tag_s1_d;
		t_s1      <= t_s1_d;
		pend_cl_q <= pend_cl_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	// topic entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_raddr];
		end
	end

	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> state_q == ST_SCAN)
		else $error("read stage busy outside scan");

	a_pend_scope: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (state_q == ST_SCAN || state_q == ST_FLUSH))
		else $error("held delivery outside publish");

	a_reply_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != S_DELIVER) |-> res.last)
		else $error("reply without last");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESOLVE |-> cur_cnt <= CNT_W'(TOPICS_PER_CLIENT))
		else $error("subscription count over limit");

	a_mem_wr_scope: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_RESOLVE || state_q == ST_SHIFT_WR))
		else $error("entry write outside subscribe or shift");

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for topic_subscription_table, with a predictor of the
// per-client topic lists and publish fanout. Depends on tst_pkg and the table RTL.
`timescale 1ns / 100ps

module tb_top
	import tst_pkg::*;
;

	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int TAIL_CYCLES  = 400;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 380;
	localparam int PHASE_ITEMS  = 60;
	localparam int MAX_GAP      = 13;
	localparam int POOL_SIZE    = 10;

	typedef struct {
		tst_cmd_t word;
		int       gap;
		bit       drain;
		bit       hold_rx;
		bit       calm;
	} cmd_slot_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_stall;
	tst_cmd_t cmd       = '0;
	logic     res_valid;
	logic     res_stall = 1'b0;
	tst_res_t res;

	// predicted table contents
	bit             online    [NUM_CLIENTS];
	int             topic_cnt [NUM_CLIENTS];
	logic [KEY_W-1:0] topic_list [NUM_CLIENTS][TOPICS_PER_CLIENT];
	tst_res_t       due_words [$];

	cmd_slot_t      cmd_backlog [$];
	int             errors;
	int             cycles;
	bit             cmd_fire;
	bit             res_fire;

	// stimulus side view of who is connected
	bit             gen_online [NUM_CLIENTS];
	int             gen_count;
	bit             gen_calm;
	bit             want_drain;
	bit             want_hold;
	logic [15:0]    key_pool [POOL_SIZE];

	int             idle_cnt;
	cmd_slot_t      nxt;
	bit             calm_now;
	int             hold_reqs;
	int             hold_seen;
	int             rx_hold;
	int             rx_wait;

	topic_subscription_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int slot_of(int c, logic [KEY_W-1:0] key);
		for (int t = 0; t < topic_cnt[c] && t < TOPICS_PER_CLIENT; t++)
			if (topic_list[c][t] == key)
				return t;
		return -1;
	endfunction

	task automatic run_command(input tst_cmd_t w);
		int c;
		int pos;
		int hits[$];
		logic [KEY_W-1:0] key;
		tst_res_t r;
		c = int'(w.client_id);
		key = w.topic_key[KEY_W-1:0];
		r.dest_client = w.client_id;
		r.last = 1'b1;
		r.status = S_SUB_OK;
		if (c >= NUM_CLIENTS)
			return;
		if (w.func == FN_CONNECT || w.func == FN_DISCONNECT) begin
			online[c] = (w.func == FN_CONNECT);
			topic_cnt[c] = 0;
		end else if (w.func <= FN_PUBLISH && online[c]) begin
			pos = slot_of(c, key);
			case (w.func)
				FN_SUBSCRIBE: begin
					// a duplicate wins over a full list
					if (pos >= 0)
						r.status = S_ALREADY;
					else if (topic_cnt[c] >= TOPICS_PER_CLIENT)
						r.status = S_LIMIT;
					else begin
						topic_list[c][topic_cnt[c]] = key;
						topic_cnt[c]++;
						r.status = S_SUB_OK;
					end
					due_words.push_back(r);
				end
				FN_UNSUBSCRIBE: begin
					if (pos < 0)
						r.status = S_NOT_SUBBED;
					else begin
						for (int t = pos; t + 1 < topic_cnt[c]; t++)
							topic_list[c][t] = topic_list[c][t + 1];
						topic_cnt[c]--;
						r.status = S_UNSUB_OK;
					end
					due_words.push_back(r);
				end
				default: begin
					for (int j = 0; j < NUM_CLIENTS; j++)
						if (online[j] && slot_of(j, key) >= 0)
							hits.push_back(j);
					foreach (hits[i]) begin
						r.status = S_DELIVER;
						r.dest_client = CID_W'(hits[i]);
						r.last = (i == hits.size() - 1);
						due_words.push_back(r);
					end
				end
			endcase
		end
	endtask

	task automatic queue_cmd(input logic [2:0] f, input int c, input logic [15:0] k);
		cmd_slot_t s;
		if (f <= FN_DISCONNECT || (f <= FN_PUBLISH && gen_online[c]))
			gen_count++;
		if (f == FN_CONNECT)
			gen_online[c] = 1'b1;
		else if (f == FN_DISCONNECT)
			gen_online[c] = 1'b0;
		s.word.func = f;
		s.word.client_id = 5'(c);
		s.word.topic_key = k;
		s.calm = gen_calm;
		s.gap = gen_calm ? 0 : $urandom_range(0, MAX_GAP);
		s.drain = want_drain;
		want_drain = 1'b0;
		s.hold_rx = want_hold && (f == FN_PUBLISH);
		if (s.hold_rx)
			want_hold = 1'b0;
		cmd_backlog.push_back(s);
	endtask

	function automatic int live_client();
		int c;
		repeat (64) begin
			c = $urandom_range(0, NUM_CLIENTS - 1);
			if (gen_online[c])
				return c;
		end
		return $urandom_range(0, NUM_CLIENTS - 1);
	endfunction

	function automatic logic [15:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return 16'($urandom);
	endfunction

	// command driver
	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || cmd_fire)) begin
			if (cmd_backlog.size() == 0)
				cmd_valid <= 1'b0;
			else if (cmd_backlog[0].drain && due_words.size() != 0)
				cmd_valid <= 1'b0;
			else if (idle_cnt < cmd_backlog[0].gap) begin
				idle_cnt++;
				cmd_valid <= 1'b0;
			end else begin
				nxt = cmd_backlog.pop_front();
				idle_cnt = 0;
				cmd <= nxt.word;
				cmd_valid <= 1'b1;
				calm_now <= nxt.calm;
				if (nxt.hold_rx)
					hold_reqs <= hold_reqs + 1;
			end
		end
	end

	// result receiver stall
	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			rx_hold = HOLD_CYCLES;
		end
		if (res_fire || cmd_fire)
			rx_wait = calm_now ? 0 : $urandom_range(0, MAX_GAP);
		if (rx_hold > 0) begin
			rx_hold--;
			res_stall <= 1'b1;
		end else if (rx_wait > 0) begin
			rx_wait--;
			res_stall <= 1'b1;
		end else
			res_stall <= 1'b0;
	end

	// monitor: predict on accepted commands, check accepted words
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			cmd_fire = arst_n && cmd_valid && !cmd_stall;
			res_fire = arst_n && res_valid && !res_stall;
			if (cmd_fire)
				run_command(cmd);
			if (res_fire) begin
				if (due_words.size() == 0) begin
					$error("unexpected word: status %0d dest_client %0d last %0d",
						res.status, res.dest_client, res.last);
					errors++;
				end else begin
					if (res.status !== due_words[0].status) begin
						$error("status: expected %0d, actual %0d",
							due_words[0].status, res.status);
						errors++;
					end
					if (res.dest_client !== due_words[0].dest_client) begin
						$error("dest_client: expected %0d, actual %0d",
							due_words[0].dest_client, res.dest_client);
						errors++;
					end
					if (res.last !== due_words[0].last) begin
						$error("last: expected %0d, actual %0d",
							due_words[0].last, res.last);
						errors++;
					end
					void'(due_words.pop_front());
				end
			end
		end
	end

	initial begin : stimulus
		int roll;
		int c;
		int n;
		int phase;
		int next_phase;
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hFFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = 16'($urandom);

		// directed part
		queue_cmd(FN_CONNECT, 0, 16'h0000);
		queue_cmd(FN_CONNECT, 31, 16'hFFFF);
		queue_cmd(FN_SUBSCRIBE, 0, 16'h0000);
		queue_cmd(FN_SUBSCRIBE, 0, 16'h0000);
		queue_cmd(FN_SUBSCRIBE, 31, 16'hFFFF);
		queue_cmd(FN_SUBSCRIBE, 31, 16'h0000);
		// publisher holds the topic itself
		queue_cmd(FN_PUBLISH, 0, 16'h0000);
		queue_cmd(FN_PUBLISH, 0, 16'h1234);
		// unconnected client is ignored
		queue_cmd(FN_SUBSCRIBE, 7, 16'h5A5A);
		queue_cmd(FN_UNSUBSCRIBE, 31, 16'hFFFF);
		queue_cmd(FN_UNSUBSCRIBE, 31, 16'hFFFF);
		for (int k = 1; k < TOPICS_PER_CLIENT; k++)
			queue_cmd(FN_SUBSCRIBE, 0, 16'(k));
		// full list: duplicate still reports already subbed
		queue_cmd(FN_SUBSCRIBE, 0, 16'h0000);
		queue_cmd(FN_SUBSCRIBE, 0, 16'h0100);
		queue_cmd(FN_UNSUBSCRIBE, 0, 16'h0003);
		queue_cmd(FN_PUBLISH, 0, 16'h0004);
		queue_cmd(3'd7, 0, 16'h0004);
		// reconnect clears the list but keeps the client
		queue_cmd(FN_CONNECT, 0, 16'h0000);
		queue_cmd(FN_PUBLISH, 0, 16'h0000);
		queue_cmd(FN_DISCONNECT, 31, 16'h0000);
		queue_cmd(FN_PUBLISH, 0, 16'h0000);

		// random part
		gen_count = 0;
		phase = 0;
		next_phase = PHASE_ITEMS;
		for (int i = 0; i < NUM_CLIENTS; i++)
			if ($urandom_range(0, 2) != 0)
				queue_cmd(FN_CONNECT, i, 16'($urandom));
		while (gen_count < RANDOM_ITEMS) begin
			if (gen_count >= next_phase) begin
				phase++;
				next_phase += PHASE_ITEMS;
				gen_calm = ($urandom_range(0, 3) == 0);
				if (phase == 2 || phase == 5)
					want_drain = 1'b1;
				if (phase == 3)
					want_hold = 1'b1;
			end
			roll = $urandom_range(0, 99);
			if (roll < 8)
				queue_cmd(FN_CONNECT, $urandom_range(0, NUM_CLIENTS - 1), 16'($urandom));
			else if (roll < 12) begin
				n = 0;
				foreach (gen_online[i])
					n += gen_online[i];
				if (n > 4)
					queue_cmd(FN_DISCONNECT, live_client(), 16'($urandom));
			end else if (roll < 47)
				queue_cmd(FN_SUBSCRIBE, live_client(), pick_key());
			else if (roll < 63)
				queue_cmd(FN_UNSUBSCRIBE, live_client(), pick_key());
			else if (roll < 93)
				queue_cmd(FN_PUBLISH, live_client(), pick_key());
			else begin
				c = $urandom_range(0, NUM_CLIENTS - 1);
				queue_cmd(3'($urandom_range(0, 7)), c, 16'($urandom));
			end
		end

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		while (cmd_backlog.size() != 0 || cmd_valid)
			@(posedge clk);
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/tst_pkg.sv
rtl/core/topic_subscription_table.sv
tb/sv/tb_top.sv
